[rtl/dpet_pkg.sv]
// ----------------------------------------------------------------------------
// Damped position easing table package
// Shared constants, command codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dpet_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned POS_W      = 16;
  localparam int unsigned STEP_W     = 15;
  localparam int unsigned GRP_W      = 8;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned COUNT_LIMIT = 4;

  // Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for every 16-bit x.
  localparam int unsigned RECIP_TEN  = 52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [CMD_W-1:0] {
    OP_AUTO    = 3'd0,
    OP_FIXED   = 3'd1,
    OP_SINGLE  = 3'd2,
    OP_SET_CUR = 3'd3,
    OP_SET_TGT = 3'd4,
    OP_SET_GRP = 3'd5
  } dpet_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MOVE,
    ST_SINGLE,
    ST_WRITE,
    ST_REPORT
  } dpet_state_e;

  typedef struct packed {
    logic load;
    logic sweep;
    logic calc;
    logic move;
    logic write;
    logic report;
  } dpet_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dpet_sts_t;

endpackage

[rtl/dpet_ctrl.sv]
// ----------------------------------------------------------------------------
// Damped position easing table controller
// Sequences sweeps, single steps, table writes and the result beat.
// ----------------------------------------------------------------------------
module dpet_ctrl
  import dpet_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  input  dpet_sts_t        sts_i,
  output dpet_cmd_t        cmd_o,
  output logic             in_stall_o
);

  dpet_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (command_i)
            OP_AUTO, OP_FIXED:                  state_d = ST_CALC;
            OP_SINGLE:                          state_d = ST_SINGLE;
            OP_SET_CUR, OP_SET_TGT, OP_SET_GRP: state_d = ST_WRITE;
            default:                            state_d = ST_REPORT;
          endcase
        end
      end
      ST_CALC:   state_d = ST_MOVE;
      ST_MOVE:   state_d = sts_i.last ? ST_REPORT : ST_CALC;
      ST_SINGLE: state_d = ST_REPORT;
      ST_WRITE:  state_d = ST_REPORT;
      ST_REPORT: state_d = sts_i.out_busy ? ST_REPORT : ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sweep  = (state_q == ST_CALC) || (state_q == ST_MOVE);
    cmd_o.calc   = (state_q == ST_CALC);
    cmd_o.move   = (state_q == ST_MOVE) || (state_q == ST_SINGLE);
    cmd_o.write  = (state_q == ST_WRITE);
    cmd_o.report = (state_q == ST_REPORT) && !sts_i.out_busy;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // A sweep always hands over to the result beat from its final entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && sts_i.last) |=> (state_q == ST_REPORT))
    else $error("sweep did not end in the result state");

endmodule

[rtl/dpet_dp.sv]
// ----------------------------------------------------------------------------
// Damped position easing table datapath
// Holds the entry table, computes steps and moves, counts unmatched entries
// and drives the result register.
// ----------------------------------------------------------------------------
module dpet_dp
  import dpet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dpet_cmd_t               cmd_i,
  output dpet_sts_t               sts_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [IDX_W-1:0]        entry_index_i,
  input  logic signed [POS_W-1:0] position_value_i,
  input  logic [STEP_W-1:0]       step_size_i,
  input  logic [GRP_W-1:0]        group_value_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [CNT_W-1:0]        unmatched_count_o,
  output logic signed [POS_W-1:0] entry_position_o,
  output logic                    entry_matched_o
);

  // Latched input item.
  logic [CMD_W-1:0]        op_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [POS_W-1:0] pos_q;
  logic [STEP_W-1:0]       step_q;
  logic [GRP_W-1:0]        grp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= command_i;
      idx_q  <= entry_index_i;
      pos_q  <= position_value_i;
      step_q <= step_size_i;
      grp_q  <= group_value_i;
    end
  end

  // Entry table.
  logic signed [POS_W-1:0] cur_q [ENTRIES];
  logic signed [POS_W-1:0] tgt_q [ENTRIES];
  logic [GRP_W-1:0]        grp_tab_q [ENTRIES];
  logic [ENTRIES-1:0]      matched_q;

  logic [IDX_W-1:0] sweep_idx_q;
  logic [CNT_W-1:0] unm_q, unm_d;
  logic [CNT_W-1:0] last_unm_q;
  logic [STEP_W-1:0] swstep_q;

  logic [IDX_W-1:0]        addr;
  logic signed [POS_W-1:0] rd_cur;
  logic signed [POS_W-1:0] rd_tgt;
  logic [GRP_W-1:0]        rd_grp;

  assign addr   = cmd_i.sweep ? sweep_idx_q : idx_q;
  assign rd_cur = cur_q[addr];
  assign rd_tgt = tgt_q[addr];
  assign rd_grp = grp_tab_q[addr];

  // Auto step: |target - current| / 10 + 1 through a reciprocal multiply.
  logic signed [POS_W:0] diff;
  logic [POS_W-1:0]      abs_diff;
  logic [31:0]           prod;
  logic [STEP_W-1:0]     auto_step;

  assign diff      = 17'(rd_tgt) - 17'(rd_cur);
  assign abs_diff  = diff[POS_W] ? POS_W'(-diff) : POS_W'(diff);
  assign prod      = 32'(abs_diff) * 32'(RECIP_TEN);
  assign auto_step = STEP_W'(prod[31:RECIP_SHIFT]) + STEP_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      swstep_q <= (op_q == OP_AUTO) ? auto_step : step_q;
    end
  end

  // Move one entry toward its target, snapping when the step would reach it.
  logic [STEP_W-1:0]       mv_step;
  logic signed [POS_W+1:0] cur_w, tgt_w, up_w, dn_w;
  logic signed [POS_W-1:0] new_pos;
  logic                    new_matched;
  logic                    do_move;

  assign mv_step = cmd_i.sweep ? swstep_q : step_q;
  assign cur_w   = 18'(rd_cur);
  assign tgt_w   = 18'(rd_tgt);
  assign up_w    = cur_w + $signed({3'b000, mv_step});
  assign dn_w    = cur_w - $signed({3'b000, mv_step});

  always_comb begin
    priority if (tgt_w > up_w) begin
      new_pos     = POS_W'(up_w);
      new_matched = 1'b0;
    end else if (tgt_w < dn_w) begin
      new_pos     = POS_W'(dn_w);
      new_matched = 1'b0;
    end else begin
      new_pos     = rd_tgt;
      new_matched = 1'b1;
    end
  end

  assign do_move = cmd_i.move && (!cmd_i.sweep || (rd_grp == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cur_q[i]     <= '0;
        tgt_q[i]     <= '0;
        grp_tab_q[i] <= '0;
      end
      matched_q <= '0;
    end else begin
      if (do_move) begin
        cur_q[addr]     <= new_pos;
        matched_q[addr] <= new_matched;
      end else if (cmd_i.write) begin
        if (op_q == OP_SET_CUR) cur_q[addr] <= pos_q;
        if (op_q == OP_SET_TGT) tgt_q[addr] <= pos_q;
        if (op_q == OP_SET_GRP) grp_tab_q[addr] <= grp_q;
      end
    end
  end

  // Sweep index and unmatched count.
  always_comb begin
    unm_d = unm_q;
    if (do_move && cmd_i.sweep && !new_matched && (unm_q < CNT_W'(COUNT_LIMIT))) begin
      unm_d = unm_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_idx_q <= '0;
      unm_q       <= '0;
      last_unm_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        sweep_idx_q <= '0;
        unm_q       <= '0;
      end else if (cmd_i.move && cmd_i.sweep) begin
        sweep_idx_q <= sweep_idx_q + IDX_W'(1);
        unm_q       <= unm_d;
        if (sts_o.last) last_unm_q <= unm_d;
      end
    end
  end

  // Result register.
  logic                    out_valid_q;
  logic [CNT_W-1:0]        out_cnt_q;
  logic signed [POS_W-1:0] out_pos_q;
  logic                    out_matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.report) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      out_cnt_q     <= last_unm_q;
      out_pos_q     <= rd_cur;
      out_matched_q <= matched_q[addr];
    end
  end

  assign sts_o.last     = (sweep_idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign unmatched_count_o = out_cnt_q;
  assign entry_position_o  = out_pos_q;
  assign entry_matched_o   = out_matched_q;

  // The running count never passes its saturation limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unm_q <= CNT_W'(COUNT_LIMIT)) && (last_unm_q <= CNT_W'(COUNT_LIMIT)))
    else $error("unmatched count beyond its limit");

  // A snapped entry sits exactly on its target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_move && new_matched) |=> (cur_q[$past(addr)] == tgt_q[$past(addr)]))
    else $error("matched entry not on its target");

endmodule

[rtl/damped_position_easing_table.sv]
// ----------------------------------------------------------------------------
// Damped position easing table
// Sixteen animated entries stepped toward their targets by sweeps or single
// steps, with set commands and one result beat per command.
// ----------------------------------------------------------------------------
// Sequence: a sweep runs one calc and one move state per entry, then the result state;
//   steps and sets pass one single or write state first, unused codes go straight to it.
// Flow: a new command is taken only in the idle state, once the last one is through,
//   as one shared step unit visits one entry at a time.
// Reset: asynchronous, clears all positions, targets, groups, matched flags
//   and the unmatched count; no result is pending after reset.
module damped_position_easing_table
  import dpet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [IDX_W-1:0]        entry_index_i,
  input  logic signed [POS_W-1:0] position_value_i,
  input  logic [STEP_W-1:0]       step_size_i,
  input  logic [GRP_W-1:0]        group_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CNT_W-1:0]        unmatched_count_o,
  output logic signed [POS_W-1:0] entry_position_o,
  output logic                    entry_matched_o
);

  dpet_cmd_t cmd;
  dpet_sts_t sts;

  dpet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  dpet_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .command_i         (command_i),
    .entry_index_i     (entry_index_i),
    .position_value_i  (position_value_i),
    .step_size_i       (step_size_i),
    .group_value_i     (group_value_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .unmatched_count_o (unmatched_count_o),
    .entry_position_o  (entry_position_o),
    .entry_matched_o   (entry_matched_o)
  );

  // An accepted beat always makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a beat");

  // A new result beat only appears while a command is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a command in progress");

endmodule
